// ===== hdl/rrfc_pkg.sv =====
// ----------------------------------------------------------------------------
// rrfc_pkg
// Types, constants and the CRC-16/MODBUS byte update for the RTU reply
// frame checker.
// ----------------------------------------------------------------------------
package rrfc_pkg;

  localparam int unsigned BUFFER_WRAP = 255;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDRESS     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_FUNCTION = 1'd1;

  localparam logic [7:0] SLAVE_ADDRESS_RST     = 8'd1;
  localparam logic [6:0] EXPECTED_FUNCTION_RST = 7'd3;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] MIN_FRAME_LEN = 8'd4;
  localparam logic [7:0] REG_HDR_LEN   = 8'd5;

  localparam logic [2:0] ST_SUCCESS   = 3'd0;
  localparam logic [2:0] ST_BAD_CRC   = 3'd1;
  localparam logic [2:0] ST_BAD_SLAVE = 3'd2;
  localparam logic [2:0] ST_BAD_FUNC  = 3'd3;
  localparam logic [2:0] ST_EXCEPTION = 3'd4;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } rrfc_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] exception_code;
    logic [7:0] frame_length;
    logic [6:0] register_count;
  } rrfc_out_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/rtu_response_frame_checker_top.sv =====
// A frame-end beat's verdict is registered into the result stage (out_valid_r, out_data_r) when the beat is accepted.
// One beat per cycle while in_ready is high; the byte-wide CRC update and header checks are combinational.
// in_ready drops only while a verdict is held and out_ready is low.
// Reset (rst_n, synchronous, active low): frame state restarts, registers
// return to slave address 1 and function 3, the result stage empties.
// ----------------------------------------------------------------------------
// rtu_response_frame_checker_top
// Checks Modbus RTU reply frames byte by byte: running CRC-16, byte count,
// header capture and one registered verdict per frame.
// ----------------------------------------------------------------------------
module rtu_response_frame_checker_top
  import rrfc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rrfc_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rrfc_out_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [7:0]  slave_addr_r;
  logic [6:0]  exp_func_r;

  logic [7:0]  cnt_r, cnt_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [7:0]  func_r, func_nxt;
  logic [7:0]  third_r, third_nxt;

  logic        out_valid_r;
  rrfc_out_t   out_data_r, res_nxt;

  logic        in_fire;
  logic        wrap;
  logic [7:0]  base_cnt;
  logic [15:0] base_crc;
  logic [7:0]  len;
  logic [7:0]  len_m5;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    wrap     = (cnt_r >= 8'(BUFFER_WRAP));
    base_cnt = wrap ? 8'd0 : cnt_r;
    base_crc = wrap ? CRC_INIT : crc_r;
    addr_nxt  = wrap ? 8'd0 : addr_r;
    func_nxt  = wrap ? 8'd0 : func_r;
    third_nxt = wrap ? 8'd0 : third_r;
    case (base_cnt)
      8'd0:    addr_nxt  = in_data.rx_byte;
      8'd1:    func_nxt  = in_data.rx_byte;
      8'd2:    third_nxt = in_data.rx_byte;
      default: ;
    endcase
    crc_nxt = crc16_byte(base_crc, in_data.rx_byte);
    len     = base_cnt + 8'd1;
    cnt_nxt = len;
    len_m5  = len - REG_HDR_LEN;

    res_nxt = '0;
    res_nxt.frame_length   = len;
    res_nxt.register_count = (len >= REG_HDR_LEN) ? len_m5[7:1] : 7'd0;
    if ((len < MIN_FRAME_LEN) || (crc_nxt != 16'd0)) begin
      res_nxt.status = ST_BAD_CRC;
    end else if (addr_nxt != slave_addr_r) begin
      res_nxt.status = ST_BAD_SLAVE;
    end else if (func_nxt[6:0] != exp_func_r) begin
      res_nxt.status = ST_BAD_FUNC;
    end else if (func_nxt[7]) begin
      res_nxt.status         = ST_EXCEPTION;
      res_nxt.exception_code = third_nxt;
    end else begin
      res_nxt.status = ST_SUCCESS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= SLAVE_ADDRESS_RST;
      exp_func_r   <= EXPECTED_FUNCTION_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SLAVE_ADDRESS:     slave_addr_r <= cfg_wdata;
        CFG_EXPECTED_FUNCTION: exp_func_r   <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      crc_r   <= CRC_INIT;
      addr_r  <= '0;
      func_r  <= '0;
      third_r <= '0;
    end else if (in_fire) begin
      if (in_data.frame_end) begin
        cnt_r   <= '0;
        crc_r   <= CRC_INIT;
        addr_r  <= '0;
        func_r  <= '0;
        third_r <= '0;
      end else begin
        cnt_r   <= cnt_nxt;
        crc_r   <= crc_nxt;
        addr_r  <= addr_nxt;
        func_r  <= func_nxt;
        third_r <= third_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && in_data.frame_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.frame_end) begin
      out_data_r <= res_nxt;
    end
  end

endmodule

// ===== hdl/rrfc_checker.sv =====
// ----------------------------------------------------------------------------
// rrfc_checker
// Port-level assertions for the RTU reply frame checker, bound to the top.
// ----------------------------------------------------------------------------
module rrfc_checker
  import rrfc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input rrfc_in_t              in_data,
  input logic                  out_valid,
  input logic                  out_ready,
  input rrfc_out_t             out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.frame_end |=> out_valid)
    else $error("frame end beat gave no verdict");

  a_exc_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_EXCEPTION) |-> out_data.exception_code == 8'd0)
    else $error("exception code set without exception status");

  a_short_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.frame_length < MIN_FRAME_LEN) |-> out_data.status == ST_BAD_CRC)
    else $error("short frame not flagged");

  a_nonzero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.frame_length != 8'd0) && (out_data.status <= ST_EXCEPTION))
    else $error("bad frame length or status code");

endmodule

bind rtu_response_frame_checker_top rrfc_checker u_rrfc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
